[src/hgfp_pkg.sv]
package hgfp_pkg;

    localparam int unsigned PATH_MAX = 255;
    localparam int unsigned TAIL_LEN = 9;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    // " HTTP/1.1", element 0 is the leading space
    localparam logic [TAIL_LEN-1:0][7:0] SFX_PAT = {
        8'h31, 8'h2e, 8'h31, 8'h2f, 8'h50, 8'h54, 8'h54, 8'h48, 8'h20
    };

    typedef enum logic [1:0] {
        PH_WAIT_LINE,
        PH_COLLECT,
        PH_WAIT_END
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_SERVE,
        EV_NOT_FOUND,
        EV_NO_SUFFIX,
        EV_OVERFLOW
    } event_t;

    typedef struct packed {
        phase_t                       phase;
        logic [1:0]                   match_count;
        logic [7:0]                   path_length;
        logic [TAIL_LEN-1:0][7:0]     tail_window;
        logic [7:0]                   last_slash_index;
        logic                         slash_seen;
    } state_t;

    typedef struct packed {
        logic       stored;
        logic [7:0] stored_index;
        event_t     event_res;
        logic [7:0] filename_start;
        logic [7:0] filename_length;
    } result_t;

    // "GET "
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0: ch = 8'h47;
            2'd1: ch = 8'h45;
            2'd2: ch = 8'h54;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    // "\r\n\r\n"
    function automatic logic [7:0] end_char(input logic [1:0] idx);
        return idx[0] ? CH_LF : CH_CR;
    endfunction

endpackage

[src/hgfp_step.sv]
module hgfp_step (
    input  hgfp_pkg::state_t  state_cur,
    input  logic [7:0]        data_byte,
    output hgfp_pkg::state_t  state_nxt,
    output hgfp_pkg::result_t result
);
    import hgfp_pkg::*;

    state_t     n;
    result_t    r;
    logic [7:0] plen;
    logic [8:0] slash_after;

    always_comb begin
        n           = state_cur;
        r           = '0;
        r.event_res = EV_NONE;
        plen        = '0;
        slash_after = '0;

        case (state_cur.phase)
            PH_WAIT_LINE: begin
                if (data_byte == get_char(state_cur.match_count)) begin
                    if (state_cur.match_count == 2'd3) begin
                        n.phase       = PH_COLLECT;
                        n.match_count = '0;
                    end else begin
                        n.match_count = state_cur.match_count + 2'd1;
                    end
                end else begin
                    n.match_count = '0;
                end
            end
            PH_COLLECT: begin
                if (data_byte == CH_CR || data_byte == CH_LF) begin
                    n.phase = PH_WAIT_END;
                end else if (data_byte != CH_NUL) begin
                    if (state_cur.path_length < 8'(PATH_MAX)) begin
                        if (state_cur.path_length >= 8'(TAIL_LEN) &&
                            (state_cur.tail_window[0] == CH_SLASH ||
                             state_cur.tail_window[0] == CH_BSLASH)) begin
                            n.last_slash_index = state_cur.path_length - 8'(TAIL_LEN);
                            n.slash_seen       = 1'b1;
                        end
                        n.tail_window  = {data_byte, state_cur.tail_window[TAIL_LEN-1:1]};
                        r.stored       = 1'b1;
                        r.stored_index = state_cur.path_length;
                        n.path_length  = state_cur.path_length + 8'd1;
                    end else begin
                        n.phase            = PH_WAIT_LINE;
                        n.match_count      = '0;
                        n.path_length      = '0;
                        n.tail_window      = '0;
                        n.last_slash_index = '0;
                        n.slash_seen       = 1'b0;
                        r.event_res        = EV_OVERFLOW;
                    end
                end
            end
            default: ;
        endcase

        // header end, counter shared with the request line match
        if (n.phase != PH_WAIT_LINE) begin
            if (data_byte == end_char(n.match_count)) begin
                if (n.match_count == 2'd3) begin
                    plen        = n.path_length - 8'(TAIL_LEN);
                    slash_after = {1'b0, n.last_slash_index} + 9'd1;
                    if (n.path_length < 8'(TAIL_LEN) || n.tail_window != SFX_PAT) begin
                        r.event_res = EV_NO_SUFFIX;
                    end else if (plen == 8'd0) begin
                        r.event_res = EV_NOT_FOUND;
                    end else if (!n.slash_seen) begin
                        r.event_res       = EV_SERVE;
                        r.filename_length = plen;
                    end else if (slash_after >= {1'b0, plen}) begin
                        r.event_res = EV_NOT_FOUND;
                    end else begin
                        r.event_res       = EV_SERVE;
                        r.filename_start  = slash_after[7:0];
                        r.filename_length = plen - slash_after[7:0];
                    end
                    n.phase            = PH_WAIT_LINE;
                    n.match_count      = '0;
                    n.path_length      = '0;
                    n.tail_window      = '0;
                    n.last_slash_index = '0;
                    n.slash_seen       = 1'b0;
                end else begin
                    n.match_count = n.match_count + 2'd1;
                end
            end else begin
                n.match_count = '0;
            end
        end
    end

    assign state_nxt = n;
    assign result    = r;

endmodule

[src/http_get_request_filename_parser.sv]
// channel  ports                                      direction  per transfer
// s_       s_valid s_ready s_data_byte                in         one request byte
// m_       m_valid m_ready m_stored m_stored_index    out        one result per byte
//          m_event_res m_filename_start m_filename_length
//
// each byte passes an input register then a result register
// one byte per cycle sustained while m_ready holds; the parse state updates as a byte enters the result register
// synchronous active-low reset returns the parser to the "GET " hunt with an empty path
// a stalled result register holds a full input register, which holds s_ready low
module http_get_request_filename_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_stored,
    output logic [7:0] m_stored_index,
    output logic [2:0] m_event_res,
    output logic [7:0] m_filename_start,
    output logic [7:0] m_filename_length
);
    import hgfp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    result_next;
    logic       advance;

    hgfp_step u_step (
        .state_cur (state_reg),
        .data_byte (in_data_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data_byte;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_stored          = out_reg.stored;
    assign m_stored_index    = out_reg.stored_index;
    assign m_event_res       = out_reg.event_res;
    assign m_filename_start  = out_reg.filename_start;
    assign m_filename_length = out_reg.filename_length;

    // a stored byte never completes a request in the same transfer
    a_store_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.stored |-> out_reg.event_res == EV_NONE)
        else $error("stored byte carries an event");

    // path is empty whenever the request line hunt is on
    a_idle_path_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_WAIT_LINE |-> state_reg.path_length == 8'd0 &&
            !state_reg.slash_seen)
        else $error("path not cleared in request line hunt");

    // a served file always has a name
    a_serve_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.event_res == EV_SERVE |-> out_reg.filename_length != 8'd0)
        else $error("served file with empty name");

    // result register does not change while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule
